FILE: hdl/stx_etb_frame_xor_checker_assert.svh
// Assertion macros shared by the frame checker modules.
`ifndef STX_ETB_FRAME_XOR_CHECKER_ASSERT_SVH
`define STX_ETB_FRAME_XOR_CHECKER_ASSERT_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is asserted.
`define STX_ETB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stx_etb assertion failed");

// Clocked check that also holds during reset.
`define STX_ETB_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("stx_etb assertion failed");

`else

`define STX_ETB_ASSERT(name, clk, rst_n, prop)
`define STX_ETB_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: hdl/stx_etb_pkg.sv
package stx_etb_pkg;

  localparam int unsigned MAX_FRAME_DEF = 4096;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 8'd1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd2;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd23;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_BODY,
    ST_TAIL_HI,
    ST_TAIL_LO
  } stx_etb_state_t;

  // Result fields of fixed width; the frame length travels beside it.
  typedef struct packed {
    logic              checksum_ok;
    logic [BYTE_W-1:0] message_code;
    logic [BYTE_W-1:0] computed_checksum;
    logic [BYTE_W-1:0] received_checksum;
    logic              length_overflow;
  } stx_etb_res_t;

endpackage

FILE: hdl/stx_etb_frame_xor_checker.sv
// A result is presented once the second checksum character has passed
// the input register and then the output register.
// Throughput: one byte per cycle while no stalled result holds back the input.
// A result stalled at the output holds back only the next checksum character.
// Reset (synchronous, rst_n low): markers return to 2 and 23, the checker
// hunts for a start marker, and both the input and output stages are empty.
module stx_etb_frame_xor_checker #(
  parameter  int unsigned MAX_FRAME = stx_etb_pkg::MAX_FRAME_DEF,
  localparam int unsigned LEN_W     = $clog2(MAX_FRAME + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [stx_etb_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_checksum_ok,
  output logic [stx_etb_pkg::BYTE_W-1:0]    out_message_code,
  output logic [LEN_W-1:0]                  out_frame_length,
  output logic [stx_etb_pkg::BYTE_W-1:0]    out_computed_checksum,
  output logic [stx_etb_pkg::BYTE_W-1:0]    out_received_checksum,
  output logic                              out_length_overflow,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stx_etb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stx_etb_pkg::BYTE_W-1:0]    cfg_data
);
  import stx_etb_pkg::*;

  logic [BYTE_W-1:0] start_marker;
  logic [BYTE_W-1:0] end_marker;
  logic              res_ready;
  logic              res_push;
  stx_etb_res_t      res;
  logic [LEN_W-1:0]  res_length;
  stx_etb_res_t      out_res;

  stx_etb_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start_marker (start_marker),
    .end_marker   (end_marker)
  );

  stx_etb_framer #(
    .MAX_FRAME (MAX_FRAME)
  ) u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .res_ready    (res_ready),
    .res_push     (res_push),
    .res          (res),
    .res_length   (res_length)
  );

  stx_etb_out_reg #(
    .LEN_W (LEN_W)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_push   (res_push),
    .res_ready  (res_ready),
    .res        (res),
    .res_length (res_length),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .out_length (out_frame_length)
  );

  assign out_checksum_ok       = out_res.checksum_ok;
  assign out_message_code      = out_res.message_code;
  assign out_computed_checksum = out_res.computed_checksum;
  assign out_received_checksum = out_res.received_checksum;
  assign out_length_overflow   = out_res.length_overflow;

endmodule

FILE: hdl/stx_etb_cfg_regs.sv
module stx_etb_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stx_etb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stx_etb_pkg::BYTE_W-1:0]      cfg_data,
  output logic [stx_etb_pkg::BYTE_W-1:0]      start_marker,
  output logic [stx_etb_pkg::BYTE_W-1:0]      end_marker
);
  import stx_etb_pkg::*;

  logic [BYTE_W-1:0] start_marker_r;
  logic [BYTE_W-1:0] end_marker_r;

  assign cfg_ready = 1'b1;

  // Writes to an index beyond the register list are taken and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_START_MARKER) begin
        start_marker_r <= cfg_data;
      end
      if (cfg_index == REG_END_MARKER) begin
        end_marker_r <= cfg_data;
      end
    end
  end

  assign start_marker = start_marker_r;
  assign end_marker   = end_marker_r;

endmodule

FILE: hdl/stx_etb_framer.sv
`include "stx_etb_frame_xor_checker_assert.svh"

module stx_etb_framer #(
  parameter  int unsigned MAX_FRAME = stx_etb_pkg::MAX_FRAME_DEF,
  localparam int unsigned LEN_W     = $clog2(MAX_FRAME + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [stx_etb_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic [stx_etb_pkg::BYTE_W-1:0] start_marker,
  input  logic [stx_etb_pkg::BYTE_W-1:0] end_marker,
  input  logic                           res_ready,
  output logic                           res_push,
  output stx_etb_pkg::stx_etb_res_t      res,
  output logic [LEN_W-1:0]               res_length
);
  import stx_etb_pkg::*;

  localparam logic [BYTE_W-1:0] CHAR_0     = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_9_END = 8'd58;
  localparam logic [BYTE_W-1:0] CHAR_A     = 8'd65;
  localparam logic [BYTE_W-1:0] CHAR_F_END = 8'd71;
  localparam logic [BYTE_W-1:0] ALPHA_OFS  = 8'd55;
  localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(MAX_FRAME);
  localparam logic [LEN_W-1:0]  LEN_ONE    = LEN_W'(1);

  function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] diff;
    diff = '0;
    if (c >= CHAR_0 && c < CHAR_9_END) begin
      diff = c - CHAR_0;
    end else if (c >= CHAR_A && c < CHAR_F_END) begin
      diff = c - ALPHA_OFS;
    end
    return diff[3:0];
  endfunction

  stx_etb_state_t    state_r, state_nxt;
  logic              st_valid_r, st_valid_nxt;
  logic [BYTE_W-1:0] st_byte_r, st_byte_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0] code_r, code_nxt;
  logic [3:0]        hi_r, hi_nxt;
  logic              ovf_r, ovf_nxt;
  logic              emit;
  logic              consume;
  logic [BYTE_W-1:0] rx_sum;

  // Only the second checksum character produces a result, so only it
  // waits for room in the output register.
  assign emit     = st_valid_r && (state_r == ST_TAIL_LO);
  assign consume  = st_valid_r && (!emit || res_ready);
  assign in_stall = st_valid_r && !consume;
  assign res_push = emit && res_ready;
  assign rx_sum   = {hi_r, hex_value(st_byte_r)};

  always_comb begin
    st_valid_nxt = st_valid_r;
    st_byte_nxt  = st_byte_r;
    if (in_valid && !in_stall) begin
      st_valid_nxt = 1'b1;
      st_byte_nxt  = in_rx_byte;
    end else if (consume) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    xor_nxt   = xor_r;
    len_nxt   = len_r;
    code_nxt  = code_r;
    hi_nxt    = hi_r;
    ovf_nxt   = ovf_r;
    if (consume) begin
      case (state_r)
        ST_HUNT: begin
          if (st_byte_r == start_marker) begin
            state_nxt = ST_BODY;
            xor_nxt   = st_byte_r;
            len_nxt   = LEN_ONE;
            code_nxt  = '0;
            hi_nxt    = '0;
            ovf_nxt   = 1'b0;
          end
        end
        ST_BODY: begin
          xor_nxt = xor_r ^ st_byte_r;
          if (st_byte_r == end_marker) begin
            state_nxt = ST_TAIL_HI;
          end else begin
            if (len_r == LEN_ONE) begin
              code_nxt = st_byte_r;
            end
            if (len_r < LEN_MAX) begin
              len_nxt = len_r + LEN_ONE;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        ST_TAIL_HI: begin
          hi_nxt    = hex_value(st_byte_r);
          state_nxt = ST_TAIL_LO;
        end
        ST_TAIL_LO: begin
          state_nxt = ST_HUNT;
        end
        default: begin
          state_nxt = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HUNT;
      st_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_byte_r <= st_byte_nxt;
    xor_r     <= xor_nxt;
    len_r     <= len_nxt;
    code_r    <= code_nxt;
    hi_r      <= hi_nxt;
    ovf_r     <= ovf_nxt;
  end

  always_comb begin
    res.checksum_ok       = (xor_r == rx_sum);
    res.message_code      = code_r;
    res.computed_checksum = xor_r;
    res.received_checksum = rx_sum;
    res.length_overflow   = ovf_r;
  end
  assign res_length = len_r;

  `STX_ETB_ASSERT(a_rearm_after_result, clk, rst_n, (consume && state_r == ST_TAIL_LO) |=> (state_r == ST_HUNT))
  `STX_ETB_ASSERT(a_len_in_range, clk, rst_n, (state_r != ST_HUNT) |-> (len_r != '0 && len_r <= LEN_MAX))
  `STX_ETB_ASSERT(a_ovf_saturated, clk, rst_n, (state_r != ST_HUNT && ovf_r) |-> (len_r == LEN_MAX))

endmodule

FILE: hdl/stx_etb_out_reg.sv
`include "stx_etb_frame_xor_checker_assert.svh"

module stx_etb_out_reg #(
  parameter int unsigned LEN_W = 13
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           res_push,
  output logic                           res_ready,
  input  stx_etb_pkg::stx_etb_res_t      res,
  input  logic [LEN_W-1:0]               res_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output stx_etb_pkg::stx_etb_res_t      out_res,
  output logic [LEN_W-1:0]               out_length
);
  import stx_etb_pkg::*;

  logic         valid_r, valid_nxt;
  stx_etb_res_t res_r;
  logic [LEN_W-1:0] len_r;

  // The slot frees up in the same cycle its transaction completes.
  assign res_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_push) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r <= res;
      len_r <= res_length;
    end
  end

  assign out_valid  = valid_r;
  assign out_res    = res_r;
  assign out_length = len_r;

  `STX_ETB_ASSERT(a_push_into_free_slot, clk, rst_n, res_push |-> (!valid_r || !out_stall))
  `STX_ETB_ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> !valid_r)

endmodule
